// ===== design/pidaw_pkg.sv =====
`default_nettype none

package pidaw_pkg;

  localparam int DATA_W  = 32;
  localparam int UDATA_W = 31;
  localparam int IDX_W   = 3;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [UDATA_W-1:0]       udata_t;
  typedef logic [IDX_W-1:0]         reg_idx_t;

  // Register indexes on the configuration channel.
  localparam reg_idx_t REG_KP   = 3'd0;
  localparam reg_idx_t REG_KI   = 3'd1;
  localparam reg_idx_t REG_KD   = 3'd2;
  localparam reg_idx_t REG_TS   = 3'd3;
  localparam reg_idx_t REG_ITS  = 3'd4;
  localparam reg_idx_t REG_LIM  = 3'd5;
  localparam reg_idx_t REG_WRAP = 3'd6;

  localparam udata_t TS_RST  = 31'd1638;
  localparam udata_t ITS_RST = 31'd2621440;
  localparam udata_t LIM_RST = 31'd327680;

  localparam data_t DATA_MAX = 32'sh7FFF_FFFF;
  localparam data_t DATA_MIN = 32'sh8000_0000;

  // 180 and 360 degrees in Q16.16.
  localparam logic signed [33:0] HALF_TURN     = 34'sd11796480;
  localparam logic signed [33:0] NEG_HALF_TURN = -34'sd11796480;
  localparam logic signed [33:0] FULL_TURN     = 34'sd23592960;

  function automatic data_t sat34(input logic signed [33:0] v);
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
      return v[31:0];
    end
    return v[33] ? DATA_MIN : DATA_MAX;
  endfunction

  // Q16.16 product: drop 16 fraction bits (floor), then saturate to 32 bits.
  function automatic data_t sat_prod(input logic signed [65:0] p);
    logic [18:0] upper;
    upper = p[65:47];
    if ((&upper) || !(|upper)) begin
      return p[47:16];
    end
    return p[65] ? DATA_MIN : DATA_MAX;
  endfunction

endpackage

`default_nettype wire

// ===== design/pidaw_cfg_if.sv =====
`default_nettype none

interface pidaw_cfg_if import pidaw_pkg::*; ();
  logic     valid;
  logic     ready;
  reg_idx_t index;
  data_t    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/pidaw_in_if.sv =====
`default_nettype none

interface pidaw_in_if import pidaw_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t target_value;
  data_t measured_value;

  modport source (output valid, output target_value, output measured_value, input ready);
  modport sink   (input valid, input target_value, input measured_value, output ready);
endinterface

`default_nettype wire

// ===== design/pidaw_out_if.sv =====
`default_nettype none

interface pidaw_out_if import pidaw_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t drive_value;

  modport source (output valid, output drive_value, input ready);
  modport sink   (input valid, input drive_value, output ready);
endinterface

`default_nettype wire

// ===== design/pidaw_mul.sv =====
`default_nettype none

// Signed 33 x 33 bit-serial multiplier: one multiplier bit per cycle.
// done pulses in the cycle after the last step, with prod holding the exact product.
module pidaw_mul import pidaw_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [32:0] a_in,
  input  logic signed [32:0] b_in,
  output logic               done,
  output logic signed [65:0] prod
);

  localparam int MUL_W = 33;
  localparam int CNT_W = $clog2(MUL_W);

  logic signed [32:0] a_r;
  logic signed [34:0] hi_r, hi_nxt;
  logic [32:0]        lo_r, lo_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;

  logic               last;
  logic signed [34:0] a_ext;
  logic signed [34:0] addend;
  logic signed [34:0] psum;

  assign last  = (cnt_r == CNT_W'(MUL_W - 1));
  assign a_ext = $signed({{2{a_r[32]}}, a_r});

  always_comb begin
    // The top multiplier bit carries negative weight, so the last step subtracts.
    if (lo_r[0]) begin
      addend = last ? -a_ext : a_ext;
    end else begin
      addend = '0;
    end
    psum   = hi_r + addend;
    hi_nxt = $signed({psum[34], psum[34:1]});
    lo_nxt = {psum[0], lo_r[32:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r  <= cnt_r + 1'b1;
      busy_r <= !last;
      done_r <= last;
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a_in;
      hi_r <= '0;
      lo_r <= b_in;
    end else if (busy_r) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
  end

  assign done = done_r;
  assign prod = $signed({hi_r[32:0], lo_r});

endmodule

`default_nettype wire

// ===== design/pid_step_with_angle_wrap.sv =====
`default_nettype none

// Channel   Dir  Beat contents
// cfg_chan  in   index (3 bits), data (32 bits)
// in_chan   in   target_value, measured_value (Q16.16 signed)
// out_chan  out  drive_value (Q16.16 signed, saturated)
//
// From acceptance to its result, an item makes five passes through one shared
// bit-serial multiplier, with a fold step for the error before them and an output step
// after them that saturates and loads the output register.
// A new item can be taken in the cycle after the result is loaded, while that result waits;
// the next result holds in the output step until the output register is free.
// Reset is synchronous, active low; it clears the integral and last error and loads
// the register defaults. Configuration beats are always taken.
module pid_step_with_angle_wrap import pidaw_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  pidaw_cfg_if.sink    cfg_chan,
  pidaw_in_if.sink     in_chan,
  pidaw_out_if.source  out_chan
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_FOLD  = 8'b0000_0010,
    S_W_INT = 8'b0000_0100,
    S_W_DER = 8'b0000_1000,
    S_W_P   = 8'b0001_0000,
    S_W_I   = 8'b0010_0000,
    S_W_D   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  data_t  kp_r, ki_r, kd_r;
  udata_t ts_r, its_r, lim_r;
  logic   wrap_r;

  data_t              integ_r, last_err_r, err_r, deriv_r, drive_r;
  logic signed [32:0] diff_r;
  logic signed [33:0] sum_r;
  logic               out_valid_r;

  logic               in_acc, out_free;
  logic               mul_start, mul_done;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_prod;
  data_t              q;

  logic signed [33:0] d_ext, d_fold;
  data_t              err_nxt;
  logic signed [32:0] integ_sum;
  data_t              integ_sat, integ_nxt;
  logic signed [32:0] der_diff;
  logic signed [33:0] sum_add;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r   <= '0;
      ki_r   <= '0;
      kd_r   <= '0;
      ts_r   <= TS_RST;
      its_r  <= ITS_RST;
      lim_r  <= LIM_RST;
      wrap_r <= 1'b0;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        REG_KP:   kp_r   <= cfg_chan.data;
        REG_KI:   ki_r   <= cfg_chan.data;
        REG_KD:   kd_r   <= cfg_chan.data;
        REG_TS:   ts_r   <= cfg_chan.data[30:0];
        REG_ITS:  its_r  <= cfg_chan.data[30:0];
        REG_LIM:  lim_r  <= cfg_chan.data[30:0];
        REG_WRAP: wrap_r <= cfg_chan.data[0];
        default: ;
      endcase
    end
  end

  assign in_chan.ready        = (state_r == S_IDLE);
  assign in_acc               = in_chan.valid && in_chan.ready;
  assign out_free             = !out_valid_r || out_chan.ready;
  assign out_chan.valid       = out_valid_r;
  assign out_chan.drive_value = drive_r;

  pidaw_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a_in  (mul_a),
    .b_in  (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign q = sat_prod(mul_prod);

  always_comb begin
    d_ext  = $signed({diff_r[32], diff_r});
    d_fold = d_ext;
    // The fold is applied once only, so a wide error may stay outside a half turn.
    if (wrap_r) begin
      if (d_ext < NEG_HALF_TURN) begin
        d_fold = d_ext + FULL_TURN;
      end else if (d_ext > HALF_TURN) begin
        d_fold = d_ext - FULL_TURN;
      end
    end
    err_nxt = sat34(d_fold);
  end

  always_comb begin
    integ_sum = $signed({integ_r[31], integ_r}) + $signed({q[31], q});
    integ_sat = sat34($signed({integ_sum[32], integ_sum}));
    // Only the positive side is limited; going over clears the integral.
    integ_nxt = ($signed({integ_sat[31], integ_sat}) > $signed({2'b00, lim_r})) ?
                '0 : integ_sat;
    der_diff  = $signed({err_r[31], err_r}) - $signed({last_err_r[31], last_err_r});
    sum_add   = sum_r + $signed({{2{q[31]}}, q});
  end

  always_comb begin
    state_nxt = state_r;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_FOLD;
        end
      end
      S_FOLD: begin
        mul_start = 1'b1;
        mul_a     = $signed({err_nxt[31], err_nxt});
        mul_b     = $signed({2'b00, ts_r});
        state_nxt = S_W_INT;
      end
      S_W_INT: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = der_diff;
          mul_b     = $signed({2'b00, its_r});
          state_nxt = S_W_DER;
        end
      end
      S_W_DER: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = $signed({kp_r[31], kp_r});
          mul_b     = $signed({err_r[31], err_r});
          state_nxt = S_W_P;
        end
      end
      S_W_P: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = $signed({ki_r[31], ki_r});
          mul_b     = $signed({integ_r[31], integ_r});
          state_nxt = S_W_I;
        end
      end
      S_W_I: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = $signed({kd_r[31], kd_r});
          mul_b     = $signed({deriv_r[31], deriv_r});
          state_nxt = S_W_D;
        end
      end
      S_W_D: begin
        if (mul_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      integ_r     <= '0;
      last_err_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_W_INT && mul_done) begin
        integ_r <= integ_nxt;
      end
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
        last_err_r  <= err_r;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      diff_r <= $signed({in_chan.target_value[31], in_chan.target_value})
              - $signed({in_chan.measured_value[31], in_chan.measured_value});
    end
    if (state_r == S_FOLD) begin
      err_r <= err_nxt;
    end
    if (state_r == S_W_DER && mul_done) begin
      deriv_r <= q;
    end
    if (state_r == S_W_P && mul_done) begin
      sum_r <= $signed({{2{q[31]}}, q});
    end
    if ((state_r == S_W_I || state_r == S_W_D) && mul_done) begin
      sum_r <= sum_add;
    end
    if (state_r == S_OUT && out_free) begin
      drive_r <= sat34(sum_r);
    end
  end

  a_accept_to_fold: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_FOLD)
    else $error("accepted beat did not move to the fold step");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == S_W_INT || state_r == S_W_DER || state_r == S_W_P ||
                  state_r == S_W_I || state_r == S_W_D))
    else $error("multiplier finished outside a wait step");

  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result appeared without passing the output step");

  a_integ_limited: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_W_DER |-> !($signed({integ_r[31], integ_r}) > $signed({2'b00, lim_r})))
    else $error("integral above its limit after update");

endmodule

`default_nettype wire
